// ===== hdl/sobol_quasirandom_generator_top_assert.svh =====
// Assertion macros for the Sobol generator.
// Used by sobol_quasirandom_generator_top; needs clk and rst_n in scope.
`ifndef SOBOL_QUASIRANDOM_GENERATOR_TOP_ASSERT_SVH
`define SOBOL_QUASIRANDOM_GENERATOR_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define SQG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sqg implication check failed");
`define SQG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sqg next-cycle check failed");
`else
`define SQG_ASSERT_IMP(label, ante, cons)
`define SQG_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/sqg_pkg.sv =====
// Shared constants, types and polynomial tables for the Sobol generator.
// No dependencies.
package sqg_pkg;

  localparam int MAX_DIMS  = 10;
  localparam int FRAC_BITS = 62;
  localparam int DIR_DEPTH = MAX_DIMS * FRAC_BITS;
  localparam int DIR_AW    = $clog2(DIR_DEPTH);
  localparam int PT_AW     = $clog2(MAX_DIMS);

  typedef logic [FRAC_BITS-1:0] frac_t;
  typedef logic [3:0]           dim_t;
  typedef logic [5:0]           col_t;
  typedef logic [DIR_AW-1:0]    dir_addr_t;

  typedef enum logic [2:0] {
    ST_BUILD,
    ST_IDLE,
    ST_TZ,
    ST_DEC,
    ST_GATHER,
    ST_RDT,
    ST_EMIT
  } state_t;

  function automatic logic [5:0] poly_of(input dim_t d);
    logic [5:0] p;
    begin
      case (d)
        4'd0: p = 6'd1;
        4'd1: p = 6'd3;
        4'd2: p = 6'd7;
        4'd3: p = 6'd11;
        4'd4: p = 6'd13;
        4'd5: p = 6'd19;
        4'd6: p = 6'd25;
        4'd7: p = 6'd37;
        4'd8: p = 6'd59;
        default: p = 6'd47;
      endcase
      return p;
    end
  endfunction

  function automatic logic [2:0] deg_of(input dim_t d);
    logic [2:0] g;
    begin
      case (d)
        4'd0: g = 3'd0;
        4'd1: g = 3'd1;
        4'd2: g = 3'd2;
        4'd3, 4'd4: g = 3'd3;
        4'd5, 4'd6: g = 3'd4;
        default: g = 3'd5;
      endcase
      return g;
    end
  endfunction

  function automatic logic [4:0] init_of(input dim_t d, input logic [2:0] j);
    logic [4:0] v;
    begin
      v = 5'd1;
      case (d)
        4'd2: v = 5'd1;
        4'd3: v = (j == 3'd1) ? 5'd3 : (j == 3'd2) ? 5'd7 : 5'd1;
        4'd4: v = (j == 3'd2) ? 5'd5 : 5'd1;
        4'd5: v = (j == 3'd1) ? 5'd3 : 5'd1;
        4'd6: v = (j == 3'd2) ? 5'd3 : (j == 3'd3) ? 5'd7 : 5'd1;
        4'd7: v = (j == 3'd1 || j == 3'd2) ? 5'd3 :
                  (j == 3'd3 || j == 3'd4) ? 5'd9 : 5'd1;
        4'd8: v = (j == 3'd1) ? 5'd3 : (j == 3'd2) ? 5'd7 :
                  (j == 3'd3) ? 5'd13 : (j == 3'd4) ? 5'd3 : 5'd1;
        4'd9: v = (j == 3'd2) ? 5'd5 : (j == 3'd3) ? 5'd11 :
                  (j == 3'd4) ? 5'd27 : 5'd1;
        default: v = 5'd1;
      endcase
      return v;
    end
  endfunction

endpackage

// ===== hdl/sqg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sqg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/sobol_quasirandom_generator_top.sv =====
// Sobol generator: after reset the direction table is filled, with requests stalled.
// Index next in order, or zero: each dimension updates its stored point (ten
// dimensions always swept), paced by the one-read-a-cycle direction and point RAMs.
// Any other index: each point is rebuilt, one direction column a cycle.
// Error: one flagged result, held until the output is free. All results wait on output stalls.
// Uses sqg_pkg, sqg_ram and the assertion macro header.
`include "sobol_quasirandom_generator_top_assert.svh"
module sobol_quasirandom_generator_top import sqg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [61:0] in_seq_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_dim_index,
  output logic [61:0] out_coord_value,
  output logic        out_last_of_point,
  output logic        out_index_error
);

  state_t state_r, state_nxt;

  // build sweep
  dim_t       bd_r, bd_nxt;
  col_t       bj_r, bj_nxt;
  dir_addr_t  baddr_r, baddr_nxt;
  frac_t      win_r [5];
  frac_t      bs;
  logic [5:0] bpoly;
  logic [2:0] bdeg;

  // request path
  frac_t      seq_r, seq_nxt;
  logic [63:0] seq_ext;
  frac_t      prev_idx_r, prev_idx_nxt;
  logic       prev_valid_r, prev_valid_nxt;
  dim_t       dim_count_r;
  logic [7:0] ones_r, ones_nxt;
  logic [2:0] pos_r [8];
  logic [2:0] pos_nxt [8];
  logic       succ_r, succ_nxt;
  col_t       t_r, t_nxt;
  logic       zero_r, zero_nxt;
  logic       rebuild_r, rebuild_nxt;
  logic [6:0] tsel;
  logic       terr;
  frac_t      gray;
  dim_t       cnt;

  dim_t       d_r, d_nxt;
  col_t       j_r, j_nxt;
  col_t       jd_r, jd_nxt;
  logic       pend_r, pend_nxt;
  dir_addr_t  base_r, base_nxt;
  frac_t      acc_r, acc_nxt;
  frac_t      pv;

  // memories
  logic       dir_we, dir_re, pt_we, pt_re;
  dir_addr_t  dir_waddr, dir_raddr;
  frac_t      dir_rdata, pt_rdata, pt_wdata;
  logic [PT_AW-1:0] pt_addr;

  // output register
  logic       out_valid_r, out_valid_nxt;
  dim_t       out_dim_r, out_dim_nxt;
  frac_t      out_val_r, out_val_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_err_r, out_err_nxt;
  logic       out_free;

  sqg_ram #(.WIDTH(FRAC_BITS), .DEPTH(DIR_DEPTH)) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (bs),
    .re    (dir_re),
    .raddr (dir_raddr),
    .rdata (dir_rdata)
  );

  sqg_ram #(.WIDTH(FRAC_BITS), .DEPTH(MAX_DIMS)) u_pt_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_addr),
    .wdata (pt_wdata),
    .re    (pt_re),
    .raddr (pt_addr),
    .rdata (pt_rdata)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign gray     = seq_r ^ (seq_r >> 1);
  assign seq_ext  = {2'b00, seq_r};
  assign cnt      = (dim_count_r == 4'd0) ? 4'd1 :
                    (dim_count_r > 4'(MAX_DIMS)) ? 4'(MAX_DIMS) : dim_count_r;
  assign pt_addr  = d_r[PT_AW-1:0];
  assign pv       = zero_r ? '0 : (rebuild_r ? acc_r : pt_rdata);
  assign pt_wdata = pv ^ dir_rdata;

  // direction numbers, scaled form of the recurrence
  assign bpoly = poly_of(bd_r);
  assign bdeg  = deg_of(bd_r);
  always_comb begin
    bs = '0;
    if (bd_r == 4'd0) begin
      bs = frac_t'(1) << (6'd61 - bj_r);
    end else if (bj_r < {3'b000, bdeg}) begin
      bs = frac_t'(init_of(bd_r, bj_r[2:0])) << (6'd61 - bj_r);
    end else begin
      bs = win_r[bdeg - 3'd1] >> bdeg;
      for (int k = 0; k < 5; k++) begin
        if ((3'(k) < bdeg) && bpoly[3'(bdeg - 3'd1 - 3'(k))]) begin
          bs = bs ^ win_r[k];
        end
      end
    end
  end

  // lowest zero bit, second stage
  always_comb begin
    tsel = 7'd64;
    for (int c = 7; c >= 0; c--) begin
      if (!ones_r[c]) begin
        tsel = {1'b0, 3'(c), pos_r[c]};
      end
    end
    terr = (tsel >= 7'(FRAC_BITS));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_BUILD:  if (baddr_r == dir_addr_t'(DIR_DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) state_nxt = ST_TZ;
      ST_TZ:     state_nxt = ST_DEC;
      ST_DEC: begin
        if (terr) begin
          if (out_free) state_nxt = ST_IDLE;
        end else if ((seq_r != '0) && !succ_r) begin
          state_nxt = ST_GATHER;
        end else begin
          state_nxt = ST_RDT;
        end
      end
      ST_GATHER: if (j_r == col_t'(FRAC_BITS - 1)) state_nxt = ST_RDT;
      ST_RDT:    state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free || d_r >= cnt) begin
          if (d_r == dim_t'(MAX_DIMS - 1)) state_nxt = ST_IDLE;
          else if (rebuild_r)              state_nxt = ST_GATHER;
          else                             state_nxt = ST_RDT;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    bd_nxt = bd_r; bj_nxt = bj_r; baddr_nxt = baddr_r;
    seq_nxt = seq_r; prev_idx_nxt = prev_idx_r; prev_valid_nxt = prev_valid_r;
    ones_nxt = ones_r; pos_nxt = pos_r; succ_nxt = succ_r;
    t_nxt = t_r; zero_nxt = zero_r; rebuild_nxt = rebuild_r;
    d_nxt = d_r; j_nxt = j_r; jd_nxt = jd_r; pend_nxt = 1'b0;
    base_nxt = base_r; acc_nxt = acc_r;
    dir_we = 1'b0; dir_waddr = baddr_r; dir_re = 1'b0; dir_raddr = base_r;
    pt_we = 1'b0; pt_re = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_dim_nxt = out_dim_r; out_val_nxt = out_val_r;
    out_last_nxt = out_last_r; out_err_nxt = out_err_r;
    in_stall = (state_r != ST_IDLE);

    if (pend_r && gray[jd_r]) begin
      acc_nxt = acc_r ^ dir_rdata;
    end

    unique case (state_r)
      ST_BUILD: begin
        dir_we    = 1'b1;
        baddr_nxt = baddr_r + 1'b1;
        if (bj_r == col_t'(FRAC_BITS - 1)) begin
          bj_nxt = '0;
          bd_nxt = bd_r + 1'b1;
        end else begin
          bj_nxt = bj_r + 1'b1;
        end
      end
      ST_IDLE: begin
        seq_nxt = in_seq_index;
      end
      ST_TZ: begin
        for (int c = 0; c < 8; c++) begin
          ones_nxt[c] = &seq_ext[8 * c +: 8];
          pos_nxt[c]  = 3'd7;
          for (int b = 7; b >= 0; b--) begin
            if (!seq_ext[8 * c + b]) pos_nxt[c] = 3'(b);
          end
        end
        succ_nxt = prev_valid_r && (seq_r == prev_idx_r + 1'b1);
      end
      ST_DEC: begin
        t_nxt       = tsel[5:0];
        zero_nxt    = (seq_r == '0);
        rebuild_nxt = (seq_r != '0) && !succ_r;
        d_nxt       = '0;
        j_nxt       = '0;
        base_nxt    = '0;
        if (terr && out_free) begin
          out_valid_nxt = 1'b1;
          out_dim_nxt   = '0;
          out_val_nxt   = '0;
          out_last_nxt  = 1'b1;
          out_err_nxt   = 1'b1;
        end
      end
      ST_GATHER: begin
        dir_re    = 1'b1;
        dir_raddr = base_r + dir_addr_t'(j_r);
        pend_nxt  = 1'b1;
        jd_nxt    = j_r;
        if (j_r == '0) acc_nxt = '0;
        j_nxt = (j_r == col_t'(FRAC_BITS - 1)) ? '0 : j_r + 1'b1;
      end
      ST_RDT: begin
        dir_re    = 1'b1;
        dir_raddr = base_r + dir_addr_t'(t_r);
        pt_re     = 1'b1;
      end
      ST_EMIT: begin
        if (out_free || d_r >= cnt) begin
          pt_we    = 1'b1;
          d_nxt    = d_r + 1'b1;
          base_nxt = base_r + dir_addr_t'(FRAC_BITS);
          if (d_r < cnt) begin
            out_valid_nxt = 1'b1;
            out_dim_nxt   = d_r;
            out_val_nxt   = pv;
            out_last_nxt  = (d_r + 1'b1 == cnt);
            out_err_nxt   = 1'b0;
          end
          if (d_r == dim_t'(MAX_DIMS - 1)) begin
            prev_idx_nxt   = seq_r;
            prev_valid_nxt = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (cfg_we) prev_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_BUILD;
      bd_r         <= '0;
      bj_r         <= '0;
      baddr_r      <= '0;
      prev_idx_r   <= '0;
      prev_valid_r <= 1'b0;
      dim_count_r  <= 4'd1;
      out_valid_r  <= 1'b0;
      pend_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      bd_r         <= bd_nxt;
      bj_r         <= bj_nxt;
      baddr_r      <= baddr_nxt;
      prev_idx_r   <= prev_idx_nxt;
      prev_valid_r <= prev_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_r       <= pend_nxt;
      if (cfg_we) dim_count_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_BUILD) begin
      win_r[0] <= bs;
      for (int i = 1; i < 5; i++) win_r[i] <= win_r[i-1];
    end
    seq_r      <= seq_nxt;
    ones_r     <= ones_nxt;
    pos_r      <= pos_nxt;
    succ_r     <= succ_nxt;
    t_r        <= t_nxt;
    zero_r     <= zero_nxt;
    rebuild_r  <= rebuild_nxt;
    d_r        <= d_nxt;
    j_r        <= j_nxt;
    jd_r       <= jd_nxt;
    base_r     <= base_nxt;
    acc_r      <= acc_nxt;
    out_dim_r  <= out_dim_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_dim_index     = out_dim_r;
  assign out_coord_value   = out_val_r;
  assign out_last_of_point = out_last_r;
  assign out_index_error   = out_err_r;

  `SQG_ASSERT_IMP(a_err_is_last, out_valid_r && out_err_r, out_last_r && out_dim_r == '0)
  `SQG_ASSERT_IMP(a_build_quiet, state_r == ST_BUILD, !out_valid_r && in_stall)
  `SQG_ASSERT_IMP(a_dim_range, out_valid_r, out_dim_r < dim_t'(MAX_DIMS))
  `SQG_ASSERT_NEXT(a_emit_hold, state_r == ST_EMIT && !out_free && d_r < cnt, state_r == ST_EMIT)

endmodule
